// ===== src/pewm_pkg.sv =====
// pewm_pkg: shared types and constants of the peptide-encoding window matcher.
// Holds the request/response word types, register indexes and the codon table.
// No dependencies.
package pewm_pkg;

   localparam int BASE_W     = 2;
   localparam int RES_W      = 5;
   localparam int POS_W      = 20;
   localparam int LEN_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 60;
   localparam int WIN_LEN_W  = 7;   // holds 3 * peptide length

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_PEPTIDE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUES_LOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUES_HIGH  = 2'd2;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              first;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] start_position;
      logic             forward_match;
      logic             reverse_match;
   } rsp_type;

   // Codon index = first*16 + second*4 + third, with A=0 C=1 G=2 U=3.
   // Stop codons translate to code 20.
   localparam logic [RES_W-1:0] CODON_TABLE [64] = '{
      5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
      5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
      5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
      5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
      5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
      5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
      5'd20, 5'd1,  5'd18, 5'd1,  5'd9,  5'd4,  5'd9,  5'd4
   };

   function automatic logic [RES_W-1:0] codon_code(logic [BASE_W-1:0] b0,
                                                   logic [BASE_W-1:0] b1,
                                                   logic [BASE_W-1:0] b2);
      return CODON_TABLE[{b0, b1, b2}];
   endfunction

endpackage

// ===== src/pewm_window.sv =====
// pewm_window: base shift window, sequence counters and the stage-one valid flag.
// Depends on pewm_pkg.
module pewm_window #(
   parameter int MAX_RESIDUES = 24,
   parameter int DEPTH        = 3 * MAX_RESIDUES,
   parameter int SEEN_W       = $clog2(DEPTH + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           advance,
   input  pewm_pkg::req_type              req_word,
   output logic                           valid_ff,
   output logic [pewm_pkg::BASE_W*DEPTH-1:0] window_ff,
   output logic [SEEN_W-1:0]              seen_ff,
   output logic [pewm_pkg::POS_W-1:0]     item_pos_ff
);
   import pewm_pkg::*;

   logic                      valid_in;
   logic [BASE_W*DEPTH-1:0]   window_in;
   logic [SEEN_W-1:0]         seen_in;
   logic [SEEN_W-1:0]         seen_base;
   logic [POS_W-1:0]          next_pos_ff;
   logic [POS_W-1:0]          next_pos_in;
   logic [POS_W-1:0]          pos_base;
   logic [POS_W-1:0]          item_pos_in;

   always_comb begin
      seen_base   = req_word.first ? '0 : seen_ff;
      pos_base    = req_word.first ? '0 : next_pos_ff;
      valid_in    = valid_ff;
      window_in   = window_ff;
      seen_in     = seen_ff;
      next_pos_in = next_pos_ff;
      item_pos_in = item_pos_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in    = 1'b1;
         // newest base enters at entry 0
         window_in   = {window_ff[BASE_W*(DEPTH-1)-1:0], req_word.base};
         item_pos_in = pos_base;
         next_pos_in = (pos_base == POS_MAX) ? pos_base : pos_base + 1'b1;
         seen_in     = (seen_base == SEEN_W'(DEPTH)) ? seen_base : seen_base + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         seen_ff     <= '0;
         next_pos_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         seen_ff     <= seen_in;
         next_pos_ff <= next_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      item_pos_ff <= item_pos_in;
   end

endmodule

// ===== src/pewm_strand_cmp.sv =====
// pewm_strand_cmp: translates every codon of the window on both strands and
// compares against the target peptide. Depends on pewm_pkg.
module pewm_strand_cmp #(
   parameter int MAX_RESIDUES = 24,
   parameter int DEPTH        = 3 * MAX_RESIDUES
) (
   input  logic [pewm_pkg::BASE_W*DEPTH-1:0]       window,
   input  logic [pewm_pkg::LEN_W-1:0]              pep_len,
   input  logic [pewm_pkg::RES_W*MAX_RESIDUES-1:0] targets,
   output logic                                    fwd_match,
   output logic                                    rev_match
);
   import pewm_pkg::*;

   localparam int IDX_W = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;

   logic [MAX_RESIDUES-1:0] fwd_ok;
   logic [MAX_RESIDUES-1:0] rev_ok;

   for (genvar j = 0; j < MAX_RESIDUES; j++) begin : g_codon
      logic [BASE_W-1:0] b0, b1, b2;
      logic [RES_W-1:0]  fwd_code;
      logic [RES_W-1:0]  rev_code;
      logic [LEN_W-1:0]  tgt_pos;
      logic [IDX_W-1:0]  tgt_idx;
      logic [RES_W-1:0]  fwd_tgt;

      assign b0 = window[BASE_W*(3*j)   +: BASE_W];
      assign b1 = window[BASE_W*(3*j+1) +: BASE_W];
      assign b2 = window[BASE_W*(3*j+2) +: BASE_W];

      // forward strand: group j counted from the newest base holds residue len-1-j
      assign fwd_code = codon_code(b2, b1, b0);
      // reverse complement: group j holds residue j, complement is bit inversion
      assign rev_code = codon_code(~b0, ~b1, ~b2);

      assign tgt_pos = pep_len - LEN_W'(j) - LEN_W'(1);
      assign tgt_idx = tgt_pos[IDX_W-1:0];
      assign fwd_tgt = targets[RES_W*tgt_idx +: RES_W];

      assign fwd_ok[j] = (LEN_W'(j) >= pep_len) || (fwd_code == fwd_tgt);
      assign rev_ok[j] = (LEN_W'(j) >= pep_len) ||
                         (rev_code == targets[RES_W*j +: RES_W]);
   end

   assign fwd_match = &fwd_ok;
   assign rev_match = &rev_ok;

endmodule

// ===== src/peptide_encoding_window_matcher_core.sv =====
// Channel | ports                          | word
// --------+--------------------------------+----------------------------------
// request | req_valid, req_ready, req_data | one base and its first flag
// result  | rsp_valid, rsp_ready, rsp_data | start position and strand flags
// config  | csr_we, csr_index, csr_wdata   | peptide length and residues
//
// One base per cycle while the request side is not stalled. A base enters
// the window register, the codon table lookups and compares run on the
// window, and a hit loads the result register once that register is free.
// Synchronous reset clears counters, valid flags, residues; length becomes 1.
// The request side stalls only while a hit waits on a result register that
// is full and not being taken.
// Depends on pewm_pkg, pewm_window, pewm_strand_cmp.
module peptide_encoding_window_matcher_core #(
   parameter int MAX_RESIDUES = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pewm_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pewm_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [pewm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pewm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pewm_pkg::*;

   localparam int DEPTH  = 3 * MAX_RESIDUES;
   localparam int SEEN_W = $clog2(DEPTH + 1);

   logic [LEN_W-1:0]       pep_len_ff;
   logic [CSR_DATA_W-1:0]  res_low_ff;
   logic [CSR_DATA_W-1:0]  res_high_ff;

   logic [LEN_W-1:0]       len_eff;
   logic [WIN_LEN_W-1:0]   win_len;
   logic [2*CSR_DATA_W-1:0] all_res;

   logic                   accept;
   logic                   advance;
   logic                   s1_valid;
   logic [BASE_W*DEPTH-1:0] window;
   logic [SEEN_W-1:0]      seen;
   logic [POS_W-1:0]       item_pos;
   logic                   fwd_match;
   logic                   rev_match;
   logic                   hit;
   logic                   out_free;
   logic                   load;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pep_len_ff  <= LEN_W'(1);
         res_low_ff  <= '0;
         res_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PEPTIDE_LENGTH: pep_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_RESIDUES_LOW:   res_low_ff  <= csr_wdata;
            CSR_RESIDUES_HIGH:  res_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero acts as one, anything past the maximum as the maximum
   always_comb begin
      len_eff = pep_len_ff;
      if (pep_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (pep_len_ff > LEN_W'(MAX_RESIDUES)) begin
         len_eff = LEN_W'(MAX_RESIDUES);
      end
   end

   assign win_len = WIN_LEN_W'(len_eff) * WIN_LEN_W'(3);
   assign all_res = {res_high_ff, res_low_ff};

   assign hit      = s1_valid && (WIN_LEN_W'(seen) >= win_len) && (fwd_match || rev_match);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = s1_valid && (!hit || out_free);
   assign load     = hit && out_free;
   assign req_ready = !s1_valid || advance;
   assign accept   = req_valid && req_ready;

   pewm_window #(
      .MAX_RESIDUES (MAX_RESIDUES),
      .DEPTH        (DEPTH),
      .SEEN_W       (SEEN_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .req_word    (req_data),
      .valid_ff    (s1_valid),
      .window_ff   (window),
      .seen_ff     (seen),
      .item_pos_ff (item_pos)
   );

   pewm_strand_cmp #(
      .MAX_RESIDUES (MAX_RESIDUES),
      .DEPTH        (DEPTH)
   ) u_strand_cmp (
      .window    (window),
      .pep_len   (len_eff),
      .targets   (all_res[RES_W*MAX_RESIDUES-1:0]),
      .fwd_match (fwd_match),
      .rev_match (rev_match)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.start_position = item_pos - (POS_W'(win_len) - POS_W'(1));
         rsp_data_in.forward_match  = fwd_match;
         rsp_data_in.reverse_match  = rev_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/pewm_checker.sv =====
// pewm_checker: port-level checks of the matcher core, bound to the top level.
// Depends on pewm_pkg and peptide_encoding_window_matcher_core.
module pewm_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  pewm_pkg::rsp_type               rsp_data
);
   import pewm_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   // a result always names at least one strand
   a_rsp_strand: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.forward_match || rsp_data.reverse_match))
      else $error("result with neither strand flag");

   // the request side stalls only behind a blocked result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without result backpressure");

   // a rising result word traces back to an accepted request word
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 rsp_valid |-> $past(req_valid && req_ready, 2))
      else $error("result word without an accepted request word");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind peptide_encoding_window_matcher_core pewm_checker u_pewm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/peptide_encoding_window_matcher_core_tb.sv =====
`timescale 1ns / 1ps
// peptide_encoding_window_matcher_core_tb: self-checking bench for the window matcher core.
// Keeps a shadow base window, translates it on both strands and checks each result word.
// Depends on pewm_pkg and peptide_encoding_window_matcher_core.
module peptide_encoding_window_matcher_core_tb;
   import pewm_pkg::*;

   localparam int WINDOW_BASES   = 72;
   localparam int PEPTIDE_MAX    = 24;
   localparam int TIMEOUT_CYCLES = 200_000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int DRAIN_GUARD    = 5000;
   localparam int RANDOM_PHASES  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [RES_W-1:0]     RES_LYS      = 5'd8;
   localparam logic [RES_W-1:0]     RES_STOP     = 5'd20;

   typedef enum logic [1:0] {NT_A, NT_C, NT_G, NT_T} nucleotide_type;

   localparam logic [23:0] DEFAULT_PROBE = {NT_G, NT_C, NT_A, NT_T, NT_G, NT_C,
                                            NT_C, NT_A, NT_G, NT_C, NT_T, NT_T};
   localparam logic [17:0] STOP_TRIPLETS = {NT_T, NT_A, NT_A, NT_T, NT_A, NT_G,
                                            NT_T, NT_G, NT_A};

   // Standard genetic code, index = first*16 + second*4 + third with A C G U.
   localparam logic [RES_W-1:0] AMINO_OF_CODON [64] = '{
      5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
      5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
      5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
      5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
      5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
      5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
      5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
      5'd20, 5'd1,  5'd18, 5'd1,  5'd9,  5'd4,  5'd9,  5'd4
   };

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the block: window newest in bits [1:0], counters and registers
   logic [2*WINDOW_BASES-1:0] shadow_window = '0;
   int unsigned               bases_held    = 0;
   logic [POS_W-1:0]          next_index    = '0;
   logic [LEN_W-1:0]          length_reg    = 5'd1;
   logic [CSR_DATA_W-1:0]     residues_lo   = '0;
   logic [CSR_DATA_W-1:0]     residues_hi   = '0;
   rsp_type                   expected_hits[$];
   logic [1:0]                motif[$];

   int          fail_count    = 0;
   int          bases_sent    = 0;
   int          hits_checked  = 0;
   int          forward_seen  = 0;
   int          reverse_seen  = 0;
   int          cycle_count   = 0;
   int          burst_left    = 0;
   int          hold_cycles   = 0;
   bit          tx_gaps       = 1'b0;
   bit          rx_stalls     = 1'b0;
   logic [15:0] stall_pattern = 16'hA5C3;

   peptide_encoding_window_matcher_core #(
      .MAX_RESIDUES(PEPTIDE_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("[peptide_encoding_window_matcher_core] ERROR");
         $finish;
      end
   end

   function automatic int effective_length();
      if (length_reg == 0) return 1;
      if (length_reg > PEPTIDE_MAX) return PEPTIDE_MAX;
      return int'(length_reg);
   endfunction

   function automatic logic [RES_W-1:0] target_residue(int k);
      if (k < 12) return residues_lo[5*k +: 5];
      return residues_hi[5*(k-12) +: 5];
   endfunction

   // Offset 0 is the oldest base as read; complemented reading starts at the newest.
   function automatic bit strand_hit(int len, bit complement);
      int         w;
      int         k;
      int         j;
      logic [5:0] codon;
      logic [1:0] nt;
      w = 3 * len;
      for (k = 0; k < len; k++) begin
         codon = '0;
         for (j = 0; j < 3; j++) begin
            if (complement) nt = 2'd3 - shadow_window[2*(3*k+j) +: 2];
            else nt = shadow_window[2*(w-1-3*k-j) +: 2];
            codon = {codon[3:0], nt};
         end
         if (AMINO_OF_CODON[codon] != target_residue(k)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void track_base(req_type word);
      int               len;
      logic [POS_W-1:0] idx;
      rsp_type          hit;
      if (word.first) begin
         bases_held = 0;
         next_index = '0;
      end
      shadow_window = {shadow_window[2*WINDOW_BASES-3:0], word.base};
      idx = next_index;
      if (next_index != POS_MAX) next_index++;
      if (bases_held < WINDOW_BASES) bases_held++;
      len = effective_length();
      if (bases_held >= 3 * len) begin
         hit.forward_match  = strand_hit(len, 1'b0);
         hit.reverse_match  = strand_hit(len, 1'b1);
         hit.start_position = idx - POS_W'(3 * len - 1);
         if (hit.forward_match || hit.reverse_match) expected_hits = {expected_hits, hit};
      end
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_word();
      return CSR_DATA_W'({$urandom, $urandom});
   endfunction

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result word: start_position %0d forward %0b reverse %0b",
                   rsp_data.start_position, rsp_data.forward_match, rsp_data.reverse_match);
            fail_count++;
         end else begin
            want = expected_hits.pop_front();
            hits_checked++;
            if (want.forward_match) forward_seen++;
            if (want.reverse_match) reverse_seen++;
            if (rsp_data.start_position !== want.start_position) begin
               $error("start_position: expected %0d, got %0d",
                      want.start_position, rsp_data.start_position);
               fail_count++;
            end
            if (rsp_data.forward_match !== want.forward_match) begin
               $error("forward_match: expected %0b, got %0b",
                      want.forward_match, rsp_data.forward_match);
               fail_count++;
            end
            if (rsp_data.reverse_match !== want.reverse_match) begin
               $error("reverse_match: expected %0b, got %0b",
                      want.reverse_match, rsp_data.reverse_match);
               fail_count++;
            end
         end
      end
      // long hold-off first, then the rotating stall pattern, or always ready with stalls off
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (rx_stalls) begin
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         if ($urandom_range(0, 63) == 0) stall_pattern = 16'($urandom);
         rsp_ready <= stall_pattern[0];
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_base(logic [1:0] nt, bit restart);
      int      gap;
      req_type word;
      if (tx_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      word.base  = nt;
      word.first = restart;
      req_valid <= 1'b1;
      req_data  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_base(word);
      bases_sent++;
   endtask

   // Drop valid and let every expected word come out, plus the pipeline tail.
   task automatic settle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (expected_hits.size() != 0 && guard < DRAIN_GUARD) begin
         @(posedge clock);
         guard++;
      end
      if (expected_hits.size() != 0) begin
         $error("%0d expected result words never arrived", expected_hits.size());
         fail_count++;
         expected_hits.delete();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PEPTIDE_LENGTH: length_reg  = value[LEN_W-1:0];
         CSR_RESIDUES_LOW:   residues_lo = value;
         CSR_RESIDUES_HIGH:  residues_hi = value;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Upper bits of the length word are junk the block must ignore.
   task automatic write_length(logic [LEN_W-1:0] len_field);
      logic [CSR_DATA_W-1:0] word;
      word = random_word();
      word[LEN_W-1:0] = len_field;
      write_csr(CSR_PEPTIDE_LENGTH, word);
   endtask

   task automatic make_motif(int len);
      motif.delete();
      repeat (3 * len) motif = {motif, 2'($urandom_range(0, 3))};
   endtask

   // Second half is the reverse complement of the first, so both strands read alike.
   task automatic make_palindrome(int len);
      int half;
      int i;
      half = 3 * len / 2;
      motif.delete();
      repeat (half) motif = {motif, 2'($urandom_range(0, 3))};
      for (i = half - 1; i >= 0; i--) motif = {motif, 2'(2'd3 - motif[i])};
   endtask

   task automatic motif_from(logic [71:0] bits, int count);
      int i;
      motif.delete();
      for (i = 0; i < count; i++) motif = {motif, bits[2*(count-1-i) +: 2]};
   endtask

   // Program the target as the translation of the motif, as read or complemented.
   task automatic load_peptide(bit complement, logic [LEN_W-1:0] len_field);
      int                    w;
      int                    k;
      int                    j;
      logic [1:0]            nt;
      logic [5:0]            codon;
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      w  = motif.size();
      lo = random_word();
      hi = random_word();
      for (k = 0; k < w / 3; k++) begin
         codon = '0;
         for (j = 0; j < 3; j++) begin
            nt = complement ? 2'd3 - motif[w-1-3*k-j] : motif[3*k+j];
            codon = {codon[3:0], nt};
         end
         if (k < 12) lo[5*k +: 5] = AMINO_OF_CODON[codon];
         else hi[5*(k-12) +: 5] = AMINO_OF_CODON[codon];
      end
      write_length(len_field);
      write_csr(CSR_RESIDUES_LOW, lo);
      write_csr(CSR_RESIDUES_HIGH, hi);
   endtask

   task automatic send_motif(bit restart, int flip_at);
      int         i;
      logic [1:0] nt;
      for (i = 0; i < motif.size(); i++) begin
         nt = motif[i];
         if (i == flip_at) nt = nt ^ 2'($urandom_range(1, 3));
         send_base(nt, restart && i == 0);
      end
   endtask

   task automatic send_noise(int count, int restart_pct);
      repeat (count) send_base(2'($urandom_range(0, 3)), $urandom_range(0, 99) < restart_pct);
   endtask

   // Registers at reset: length 1, all residues alanine; no first mark at all.
   task automatic test_default_registers();
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      motif_from(DEFAULT_PROBE, 12);
      send_motif(1'b0, -1);
      send_noise(4, 0);
   endtask

   task automatic test_register_aliases();
      tx_gaps   = 1'b0;
      rx_stalls = 1'b1;
      make_motif(1);
      load_peptide(1'b0, 5'd0);
      write_csr(CSR_UNMAPPED, random_word());
      send_motif(1'b1, -1);
      send_noise(4, 0);
      make_motif(PEPTIDE_MAX);
      load_peptide(1'b0, 5'd31);
      send_motif(1'b1, -1);
      send_noise(3, 0);
      load_peptide(1'b1, 5'd25);
      send_motif(1'b1, -1);
   endtask

   task automatic test_strand_matches();
      tx_gaps   = 1'b1;
      rx_stalls = 1'b0;
      make_motif(3);
      load_peptide(1'b0, 5'd3);
      send_noise(2, 100);
      send_motif(1'b0, -1);
      make_motif(4);
      load_peptide(1'b1, 5'd4);
      send_motif(1'b1, -1);
      make_palindrome(2);
      load_peptide(1'b0, 5'd2);
      send_motif(1'b1, -1);
      make_palindrome(6);
      load_peptide(1'b1, 5'd6);
      send_motif(1'b1, -1);
   endtask

   task automatic test_stop_codons();
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      motif_from(STOP_TRIPLETS, 9);
      load_peptide(1'b0, 5'd3);
      send_motif(1'b1, -1);
      load_peptide(1'b1, 5'd3);
      send_motif(1'b1, -1);
   endtask

   // Residue codes above the stop code never come out of translation.
   task automatic test_unreachable_residue();
      logic [CSR_DATA_W-1:0] lo;
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      lo = random_word();
      lo[RES_W-1:0] = RES_STOP + 5'($urandom_range(1, 11));
      write_length(5'd2);
      write_csr(CSR_RESIDUES_LOW, lo);
      send_noise(20, 5);
      write_length(5'd24);
      write_csr(CSR_RESIDUES_LOW, '1);
      write_csr(CSR_RESIDUES_HIGH, '1);
      send_noise(80, 0);
   endtask

   // A first mark empties the window; a short sequence must not match.
   task automatic test_restart();
      int i;
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      make_motif(4);
      load_peptide(1'b0, 5'd4);
      send_noise(5, 100);
      for (i = 0; i < motif.size() - 1; i++) send_base(motif[i], i == 0);
      send_motif(1'b1, -1);
      send_base(motif[0], 1'b1);
      send_base(motif[0], 1'b1);
   endtask

   // A new length applies to the bases already held.
   task automatic test_length_change();
      tx_gaps   = 1'b0;
      rx_stalls = 1'b1;
      make_motif(2);
      load_peptide(1'b0, 5'd2);
      send_noise(3, 0);
      send_motif(1'b0, -1);
      write_length(5'd1);
      send_noise(3, 0);
      write_length(5'd2);
      send_noise(3, 0);
   endtask

   // Hold the result side off while a hit stream keeps coming.
   task automatic test_backpressure();
      logic [CSR_DATA_W-1:0] lo;
      tx_gaps   = 1'b0;
      rx_stalls = 1'b0;
      lo = random_word();
      lo[RES_W-1:0] = RES_LYS;
      write_length(5'd1);
      write_csr(CSR_RESIDUES_LOW, lo);
      hold_cycles = 80;
      send_base(NT_A, 1'b1);
      repeat (40) send_base(NT_A, 1'b0);
      rx_stalls = 1'b1;
      repeat (30) send_base(NT_A, 1'b0);
   endtask

   task automatic test_random_phases();
      int               phase;
      int               len;
      int               mode;
      int               start;
      logic [LEN_W-1:0] len_field;
      logic [CSR_DATA_W-1:0] lo;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 4);
            7, 8:                len = $urandom_range(5, 12);
            default:             len = $urandom_range(13, PEPTIDE_MAX);
         endcase
         len_field = LEN_W'(len);
         if (len == 1 && $urandom_range(0, 1) == 1) len_field = '0;
         if (len == PEPTIDE_MAX && $urandom_range(0, 1) == 1)
            len_field = LEN_W'($urandom_range(PEPTIDE_MAX + 1, 31));
         mode = $urandom_range(0, 9);
         if (mode == 8 && len % 2 == 0) make_palindrome(len);
         else make_motif(len);
         load_peptide(mode == 6 || mode == 7, len_field);
         if (mode == 9) begin
            lo = residues_lo;
            lo[RES_W-1:0] = RES_STOP + 5'($urandom_range(1, 11));
            write_csr(CSR_RESIDUES_LOW, lo);
         end
         tx_gaps   = $urandom_range(0, 3) != 0;
         rx_stalls = $urandom_range(0, 3) != 0;
         start = bases_sent;
         while (bases_sent - start < 64) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: send_motif($urandom_range(0, 2) == 0, -1);
               5, 6:          send_motif(1'b0, $urandom_range(0, motif.size() - 1));
               default:       send_noise($urandom_range(1, 6), 10);
            endcase
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_registers();
      test_register_aliases();
      test_strand_matches();
      test_stop_codons();
      test_unreachable_residue();
      test_restart();
      test_length_change();
      test_backpressure();
      test_random_phases();
      settle();
      $display("sent %0d bases, checked %0d hits (%0d forward, %0d reverse strand)",
               bases_sent, hits_checked, forward_seen, reverse_seen);
      $display("lengths 1 to 24 with aliases, stop and unreachable residues, restarts, stalls");
      if (fail_count == 0) begin
         $display("[peptide_encoding_window_matcher_core] OK");
      end else begin
         $display("[peptide_encoding_window_matcher_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/pewm_pkg.sv
src/pewm_window.sv
src/pewm_strand_cmp.sv
src/peptide_encoding_window_matcher_core.sv
src/pewm_checker.sv
tb/peptide_encoding_window_matcher_core_tb.sv
